// ----- design/ddo_pkg.sv -----
// Shared types, constants and tables for the differential drive odometry block.
package ddo_pkg;

  localparam int CORDIC_STAGES = 24;

  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 176;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [7:0]  VALID_TAG   = 8'h95;
  localparam logic [33:0] CORDIC_GAIN = 34'd652032874;
  localparam logic [31:0] US_PER_S    = 32'd1000000;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_RESET  = 1'b1;

  localparam logic CFG_DIST_PER_TICK    = 1'b0;
  localparam logic CFG_HEADING_PER_TICK = 1'b1;

  localparam logic [1:0] STAT_UPDATED = 2'd0;
  localparam logic [1:0] STAT_BAD_TAG = 2'd1;
  localparam logic [1:0] STAT_RESET   = 2'd2;
  localparam logic [1:0] STAT_UNUSED  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_C,
    S_MUL_A,
    S_CORDIC,
    S_MUL_X,
    S_MUL_Y,
    S_MUL_LV,
    S_DIV_LV,
    S_MUL_AV,
    S_DIV_AV,
    S_DONE
  } ddo_state_t;

  function automatic logic [31:0] ddo_atan(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ----- design/differential_drive_odometry.sv -----
// Differential drive wheel odometry: one sequencer around a shift-add multiplier,
// a CORDIC rotator and a restoring divider.
//
// For an encoder sample, the work is six 32-step shift-add multiplications,
// CORDIC_STAGES (24) CORDIC rotations and two 50-step restoring divisions, at
// one step per cycle. With zero elapsed time the velocity steps are skipped.
// For a reset command or a bad reply tag, out_tvalid rises in the cycle after
// the transfer. The result can be taken in the cycle it appears. The input is
// ready again in the cycle after the result has been taken.
module differential_drive_odometry (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // reply_tag[7:0], left_count[39:8], right_count[71:40], elapsed_us[95:72]
  input  logic [ddo_pkg::IN_TDATA_W-1:0]    in_tdata,
  // command
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // pos_x[31:0], pos_y[63:32], heading[95:64], linear_velocity[127:96],
  // angular_velocity[175:128]
  output logic [ddo_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // status
  output logic [ddo_pkg::OUT_TUSER_W-1:0]   out_tuser,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_index,
  input  logic [ddo_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import ddo_pkg::*;

  localparam int MW = 74;

  ddo_state_t state_r, state_nxt;

  logic [31:0] dpt_r, hpt_r;
  logic [31:0] prev_l_r, prev_l_nxt, prev_r_r, prev_r_nxt;
  logic [31:0] x_r, x_nxt, y_r, y_nxt, th_r, th_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [31:0] lin_r, lin_nxt;
  logic [47:0] ang_r, ang_nxt;

  logic signed [32:0] sum_r, sum_nxt, diff_r, diff_nxt;
  logic [23:0] e_r, e_nxt;
  logic [63:0] cmag_r, cmag_nxt;
  logic [64:0] amag_r, amag_nxt;
  logic [31:0] hstep_r, hstep_nxt;
  logic        flip_r, flip_nxt;
  logic signed [33:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [32:0] cz_r, cz_nxt;
  logic [31:0] c16_r, c16_nxt;
  logic        mneg_r, mneg_nxt;
  logic [MW-1:0] acc_r, acc_nxt, ma_r, ma_nxt;
  logic [31:0] mb_r, mb_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [23:0] rem_r, rem_nxt;
  logic [49:0] dq_r, dq_nxt;
  logic        ovf_r, ovf_nxt;

  logic [7:0]  in_tag;
  logic [31:0] in_l, in_r, dl, dr;
  logic [23:0] in_e;
  logic [MW-1:0] acc_step;
  logic [24:0] rem2, rem_sub;
  logic        rem_ge;
  logic [23:0] rem_step;
  logic [49:0] dq_step;
  logic signed [33:0] dx, dy, cx_step, cy_step;
  logic signed [32:0] cz_step, atan_s;
  logic signed [33:0] cos_v, sin_v;
  logic [31:0] ang_w;
  logic        flip_w;
  logic        mul_last, cordic_last, div_last;
  logic [40:0] lv41;
  logic [32:0] lv;
  logic [48:0] av49;

  assign in_tag = in_tdata[7:0];
  assign in_l   = in_tdata[39:8];
  assign in_r   = in_tdata[71:40];
  assign in_e   = in_tdata[95:72];
  assign dl     = in_l - prev_l_r;
  assign dr     = in_r - prev_r_r;

  assign mul_last    = cnt_r == 6'd31;
  assign cordic_last = cnt_r == 6'(CORDIC_STAGES - 1);
  assign div_last    = cnt_r == 6'd49;

  assign acc_step = mb_r[0] ? acc_r + ma_r : acc_r;

  assign rem2     = {rem_r, dq_r[49]};
  assign rem_ge   = rem2 >= {1'b0, e_r};
  assign rem_sub  = rem2 - {1'b0, e_r};
  assign rem_step = rem_ge ? rem_sub[23:0] : rem2[23:0];
  assign dq_step  = {dq_r[48:0], rem_ge};

  assign dx      = cy_r >>> cnt_r[4:0];
  assign dy      = cx_r >>> cnt_r[4:0];
  assign atan_s  = $signed({1'b0, ddo_atan(cnt_r[4:0])});
  assign cx_step = cz_r[32] ? cx_r + dx : cx_r - dx;
  assign cy_step = cz_r[32] ? cy_r - dy : cy_r + dy;
  assign cz_step = cz_r[32] ? cz_r + atan_s : cz_r - atan_s;
  assign cos_v   = flip_r ? -cx_step : cx_step;
  assign sin_v   = flip_r ? -cy_r : cy_r;

  assign flip_w = th_r[31] ^ th_r[30];
  assign ang_w  = flip_w ? th_r + 32'h80000000 : th_r;

  assign lv41 = (ovf_r || dq_step > 50'h10000000000) ? 41'h10000000000 : dq_step[40:0];
  assign lv   = lv41[40:8];
  assign av49 = (ovf_r || dq_step > 50'h1000000000000) ? 49'h1000000000000 : dq_step[48:0];

  function automatic logic [32:0] abs33(input logic signed [32:0] v);
    return v[32] ? 33'(~v + 33'd1) : 33'(v);
  endfunction

  function automatic logic [31:0] abs34(input logic signed [33:0] v);
    logic [33:0] m;
    m = v[33] ? 34'(~v + 34'd1) : 34'(v);
    return m[31:0];
  endfunction

  function automatic logic [53:0] clamp54(input logic [64:0] v);
    return (v[64:53] != 12'd0) ? 54'h20000000000000 : v[53:0];
  endfunction

  function automatic logic [31:0] pos_add(input logic [31:0] p, input logic [63:0] prod,
                                          input logic neg);
    logic signed [65:0] sp, dlt, s;
    logic [31:0] res;
    sp  = neg ? -$signed({2'b00, prod}) : $signed({2'b00, prod});
    dlt = sp >>> 30;
    s   = $signed({{34{p[31]}}, p}) + dlt;
    if (s > 66'sh7FFFFFFF) begin
      res = 32'h7FFFFFFF;
    end else if (s < -66'sh80000000) begin
      res = 32'h80000000;
    end else begin
      res = s[31:0];
    end
    return res;
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == CMD_RESET || in_tag != VALID_TAG) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_MUL_C;
          end
        end
      end
      S_MUL_C:  if (mul_last) state_nxt = S_MUL_A;
      S_MUL_A:  if (mul_last) state_nxt = S_CORDIC;
      S_CORDIC: if (cordic_last) state_nxt = S_MUL_X;
      S_MUL_X:  if (mul_last) state_nxt = S_MUL_Y;
      S_MUL_Y:  if (mul_last) state_nxt = (e_r == 24'd0) ? S_DONE : S_MUL_LV;
      S_MUL_LV: if (mul_last) state_nxt = S_DIV_LV;
      S_DIV_LV: if (div_last) state_nxt = S_MUL_AV;
      S_MUL_AV: if (mul_last) state_nxt = S_DIV_AV;
      S_DIV_AV: if (div_last) state_nxt = S_DONE;
      S_DONE:   if (out_tready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_tready  = state_r == S_IDLE;
    out_tvalid = state_r == S_DONE;
    out_tdata  = {ang_r, lin_r, th_r, y_r, x_r};
    out_tuser  = status_r;
  end

  // datapath
  always_comb begin
    prev_l_nxt = prev_l_r;
    prev_r_nxt = prev_r_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    th_nxt     = th_r;
    status_nxt = status_r;
    lin_nxt    = lin_r;
    ang_nxt    = ang_r;
    sum_nxt    = sum_r;
    diff_nxt   = diff_r;
    e_nxt      = e_r;
    cmag_nxt   = cmag_r;
    amag_nxt   = amag_r;
    hstep_nxt  = hstep_r;
    flip_nxt   = flip_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    cz_nxt     = cz_r;
    c16_nxt    = c16_r;
    mneg_nxt   = mneg_r;
    acc_nxt    = acc_step;
    ma_nxt     = {ma_r[MW-2:0], 1'b0};
    mb_nxt     = {1'b0, mb_r[31:1]};
    cnt_nxt    = cnt_r + 6'd1;
    rem_nxt    = rem_step;
    dq_nxt     = dq_step;
    ovf_nxt    = ovf_r;
    case (state_r)
      S_IDLE: begin
        lin_nxt = 32'd0;
        ang_nxt = 48'd0;
        if (in_tuser == CMD_RESET) begin
          prev_l_nxt = 32'd0;
          prev_r_nxt = 32'd0;
          x_nxt      = 32'd0;
          y_nxt      = 32'd0;
          th_nxt     = 32'd0;
          status_nxt = STAT_RESET;
        end else if (in_tag != VALID_TAG) begin
          status_nxt = STAT_BAD_TAG;
        end else begin
          status_nxt = STAT_UPDATED;
          sum_nxt    = $signed({dl[31], dl}) + $signed({dr[31], dr});
          diff_nxt   = $signed({dr[31], dr}) - $signed({dl[31], dl});
          e_nxt      = in_e;
        end
        if (in_tvalid && in_tuser == CMD_SAMPLE && in_tag == VALID_TAG) begin
          prev_l_nxt = in_l;
          prev_r_nxt = in_r;
        end
        acc_nxt = '0;
        ma_nxt  = MW'(abs33($signed({dl[31], dl}) + $signed({dr[31], dr})));
        mb_nxt  = dpt_r;
        cnt_nxt = 6'd0;
      end
      S_MUL_C: begin
        if (mul_last) begin
          cmag_nxt = acc_step[64:1];
          acc_nxt  = '0;
          ma_nxt   = MW'(abs33(diff_r));
          mb_nxt   = hpt_r;
          cnt_nxt  = 6'd0;
        end
      end
      S_MUL_A: begin
        if (mul_last) begin
          amag_nxt  = acc_step[64:0];
          hstep_nxt = diff_r[32] ? 32'(~acc_step[31:0] + 32'd1) : acc_step[31:0];
          flip_nxt  = flip_w;
          cx_nxt    = $signed(CORDIC_GAIN);
          cy_nxt    = '0;
          cz_nxt    = $signed({ang_w[31], ang_w});
          cnt_nxt   = 6'd0;
        end
      end
      S_CORDIC: begin
        cx_nxt = cx_step;
        cy_nxt = cy_step;
        cz_nxt = cz_step;
        if (cordic_last) begin
          th_nxt   = th_r + hstep_r;
          c16_nxt  = (cmag_r[63:40] != 24'd0) ? 32'hFFFFFFFF : cmag_r[39:8];
          mneg_nxt = sum_r[32] ^ cos_v[33];
          acc_nxt  = '0;
          ma_nxt   = MW'((cmag_r[63:40] != 24'd0) ? 32'hFFFFFFFF : cmag_r[39:8]);
          mb_nxt   = abs34(cos_v);
          cnt_nxt  = 6'd0;
        end
      end
      S_MUL_X: begin
        if (mul_last) begin
          x_nxt    = pos_add(x_r, acc_step[63:0], mneg_r);
          mneg_nxt = sum_r[32] ^ sin_v[33];
          acc_nxt  = '0;
          ma_nxt   = MW'(c16_r);
          mb_nxt   = abs34(sin_v);
          cnt_nxt  = 6'd0;
        end
      end
      S_MUL_Y: begin
        if (mul_last) begin
          y_nxt   = pos_add(y_r, acc_step[63:0], mneg_r);
          acc_nxt = '0;
          ma_nxt  = MW'(clamp54({1'b0, cmag_r}));
          mb_nxt  = US_PER_S;
          cnt_nxt = 6'd0;
        end
      end
      S_MUL_LV, S_MUL_AV: begin
        if (mul_last) begin
          ovf_nxt = acc_step[73:50] >= e_r;
          rem_nxt = acc_step[73:50];
          dq_nxt  = acc_step[49:0];
          cnt_nxt = 6'd0;
        end
      end
      S_DIV_LV: begin
        if (div_last) begin
          if (!sum_r[32]) begin
            lin_nxt = (lv > 33'h07FFFFFFF) ? 32'h7FFFFFFF : lv[31:0];
          end else begin
            lin_nxt = (lv > 33'h080000000) ? 32'h80000000 : 32'(~lv[31:0] + 32'd1);
          end
          acc_nxt = '0;
          ma_nxt  = MW'(clamp54(amag_r));
          mb_nxt  = US_PER_S;
          cnt_nxt = 6'd0;
        end
      end
      S_DIV_AV: begin
        if (div_last) begin
          if (!diff_r[32]) begin
            ang_nxt = (av49 > 49'h07FFFFFFFFFFF) ? 48'h7FFFFFFFFFFF : av49[47:0];
          end else begin
            ang_nxt = (av49 > 49'h0800000000000) ? 48'h800000000000
                                                 : 48'(~av49[47:0] + 48'd1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      dpt_r    <= '0;
      hpt_r    <= '0;
      prev_l_r <= '0;
      prev_r_r <= '0;
      x_r      <= '0;
      y_r      <= '0;
      th_r     <= '0;
      status_r <= STAT_UPDATED;
      lin_r    <= '0;
      ang_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en && cfg_index == CFG_DIST_PER_TICK) begin
        dpt_r <= cfg_wdata;
      end
      if (cfg_wr_en && cfg_index == CFG_HEADING_PER_TICK) begin
        hpt_r <= cfg_wdata;
      end
      if (state_r != S_IDLE || in_tvalid) begin
        prev_l_r <= prev_l_nxt;
        prev_r_r <= prev_r_nxt;
        x_r      <= x_nxt;
        y_r      <= y_nxt;
        th_r     <= th_nxt;
        status_r <= status_nxt;
        lin_r    <= lin_nxt;
        ang_r    <= ang_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_r   <= sum_nxt;
    diff_r  <= diff_nxt;
    e_r     <= e_nxt;
    cmag_r  <= cmag_nxt;
    amag_r  <= amag_nxt;
    hstep_r <= hstep_nxt;
    flip_r  <= flip_nxt;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    cz_r    <= cz_nxt;
    c16_r   <= c16_nxt;
    mneg_r  <= mneg_nxt;
    acc_r   <= acc_nxt;
    ma_r    <= ma_nxt;
    mb_r    <= mb_nxt;
    cnt_r   <= cnt_nxt;
    rem_r   <= rem_nxt;
    dq_r    <= dq_nxt;
    ovf_r   <= ovf_nxt;
  end

endmodule

// ----- design/ddo_chk.sv -----
// Port checker for the differential drive odometry block, with its bind.
module ddo_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ddo_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [ddo_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import ddo_pkg::*;

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready straight after a transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != STAT_UNUSED)
    else $error("unused status code");

  a_reset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STAT_RESET |-> out_tdata == '0)
    else $error("reset result not zero");

endmodule

bind differential_drive_odometry ddo_chk u_ddo_chk (.*);

// ----- tb/sv/ddo_checker.sv -----
// Checker for the odometry block: watches all channels, predicts each result and compares.
module ddo_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [ddo_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [ddo_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [ddo_pkg::OUT_TUSER_W-1:0] out_tuser,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_index,
  input  logic [ddo_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                              fails,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ddo_pkg::*;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] heading;
    logic [31:0] lin_vel;
    logic [47:0] ang_vel;
  } pose_report_t;

  localparam longint ANG_MAX = 64'sd140737488355327;
  localparam longint ANG_MIN = -64'sd140737488355328;

  pose_report_t pose_q[$];

  logic [31:0] dist_tick, head_tick;
  logic [31:0] last_l, last_r, px, py, th;

  longint rot_tab [0:31] = '{
    'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
    'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
    'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
    'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
    'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001,
    'h00000001, 'h00000000};

  function automatic void cos_sin(input logic [31:0] a, output longint c, output longint s);
    logic [31:0] t;
    logic        flip;
    longint      x, y, z, dx, dy;
    t = a + 32'h40000000;
    flip = t[31];
    if (flip) a = a + 32'h80000000;
    z = longint'($signed(a));
    x = longint'(CORDIC_GAIN);
    y = 0;
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= rot_tab[i];
      end else begin
        x += dx; y -= dy; z += rot_tab[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [63:0] rate_of(input logic [63:0] m, input logic [63:0] e,
                                          input logic [63:0] cap);
    logic [63:0] q, r, v, us;
    us = 64'(US_PER_S);
    q = m / e;
    r = m % e;
    if (q > cap / us) return cap;
    v = q * us + (r * us) / e;
    return (v > cap) ? cap : v;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic integrate(input logic cmd, input logic [7:0] tag, input logic [31:0] l,
                           input logic [31:0] r, input logic [23:0] e);
    pose_report_t rep;
    longint       dl, dr, sum, diff, trav, cv, sv, nx, ny, lin, ang;
    logic [63:0]  msum, mdiff, cm24, c16, lv, av, hstep;
    lin = 0;
    ang = 0;
    if (cmd == CMD_RESET) begin
      last_l = 0; last_r = 0; px = 0; py = 0; th = 0;
      rep.status = STAT_RESET;
    end else if (tag != VALID_TAG) begin
      rep.status = STAT_BAD_TAG;
    end else begin
      dl = longint'($signed(l - last_l));
      dr = longint'($signed(r - last_r));
      sum = dl + dr;
      diff = dr - dl;
      msum = (sum < 0) ? 64'(-sum) : 64'(sum);
      mdiff = (diff < 0) ? 64'(-diff) : 64'(diff);
      cm24 = (msum * {32'b0, dist_tick}) >> 1;
      c16 = cm24 >> 8;
      if (c16 > 64'hFFFFFFFF) c16 = 64'hFFFFFFFF;
      trav = (sum < 0) ? -longint'(c16) : longint'(c16);
      cos_sin(th, cv, sv);
      nx = clamp(longint'($signed(px)) + ((trav * cv) >>> 30), -64'sd2147483648, 64'sd2147483647);
      ny = clamp(longint'($signed(py)) + ((trav * sv) >>> 30), -64'sd2147483648, 64'sd2147483647);
      px = nx[31:0];
      py = ny[31:0];
      hstep = 64'(diff) * {32'b0, head_tick};
      th = th + hstep[31:0];
      last_l = l;
      last_r = r;
      if (e != 0) begin
        lv = rate_of(cm24, 64'(e), 64'd1 << 40) >> 8;
        av = rate_of(mdiff * {32'b0, head_tick}, 64'(e), 64'd1 << 48);
        lin = clamp((sum < 0) ? -longint'(lv) : longint'(lv), -64'sd2147483648,
                    64'sd2147483647);
        ang = clamp((diff < 0) ? -longint'(av) : longint'(av), ANG_MIN, ANG_MAX);
      end
      rep.status = STAT_UPDATED;
    end
    rep.pos_x = px;
    rep.pos_y = py;
    rep.heading = th;
    rep.lin_vel = lin[31:0];
    rep.ang_vel = ang[47:0];
    pose_q.push_back(rep);
  endtask

  task automatic compare_report();
    pose_report_t want;
    if (pose_q.size() == 0) begin
      $error("unexpected result: status %0d", out_tuser);
      fails++;
      return;
    end
    want = pose_q.pop_front();
    if (out_tuser !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, out_tuser); fails++;
    end
    if (out_tdata[31:0] !== want.pos_x) begin
      $error("pos_x: expected %h, got %h", want.pos_x, out_tdata[31:0]); fails++;
    end
    if (out_tdata[63:32] !== want.pos_y) begin
      $error("pos_y: expected %h, got %h", want.pos_y, out_tdata[63:32]); fails++;
    end
    if (out_tdata[95:64] !== want.heading) begin
      $error("heading: expected %h, got %h", want.heading, out_tdata[95:64]); fails++;
    end
    if (out_tdata[127:96] !== want.lin_vel) begin
      $error("linear_velocity: expected %h, got %h", want.lin_vel, out_tdata[127:96]);
      fails++;
    end
    if (out_tdata[175:128] !== want.ang_vel) begin
      $error("angular_velocity: expected %h, got %h", want.ang_vel, out_tdata[175:128]);
      fails++;
    end
  endtask

  initial begin
    fails = 0;
    dist_tick = 0; head_tick = 0;
    last_l = 0; last_r = 0; px = 0; py = 0; th = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) compare_report();
      if (cfg_wr_en) begin
        if (cfg_index == CFG_DIST_PER_TICK) dist_tick = cfg_wdata;
        else head_tick = cfg_wdata;
      end
      if (in_tvalid && in_tready)
        integrate(in_tuser, in_tdata[7:0], in_tdata[39:8], in_tdata[71:40], in_tdata[95:72]);
    end
    pending = pose_q.size();
  end

  initial pending = 0;
endmodule

// ----- tb/sv/tb_differential_drive_odometry.sv -----
// Top of the odometry testbench: clock, reset, stimulus, receiver stalls and verdict.
module tb_differential_drive_odometry;
  timeunit 1ns;
  timeprecision 1ps;
  import ddo_pkg::*;

  logic                   clk = 0;
  logic                   rst_n;
  logic                   in_tvalid, in_tready, in_tuser;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid, out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_wr_en, cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  int                     fails, pending;

  int          gap_pct = 0, stall_pct = 0;
  int          hold_asks = 0, hold_seen = 0, hold_left = 0;
  int          quiet = 0;
  logic [31:0] cur_l = 0, cur_r = 0;

  localparam int QUIET_LIMIT = 20000;

  always #6 clk = ~clk;

  differential_drive_odometry uut (.*);

  ddo_checker chk (.*);

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = 600;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send(input logic cmd, input logic [7:0] tag, input logic [31:0] l,
                      input logic [31:0] r, input logic [23:0] e);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {e, r, l, tag};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd == CMD_RESET) begin
      cur_l = 0; cur_r = 0;
    end else if (tag == VALID_TAG) begin
      cur_l = l; cur_r = r;
    end
    if ($urandom_range(99) < gap_pct) begin
      gap = $urandom_range(1, 40);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_reg(input logic idx, input logic [31:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_item();
    int          k;
    logic [31:0] l, r;
    logic [23:0] e;
    logic [7:0]  tag;
    k = $urandom_range(99);
    tag = VALID_TAG;
    if (k < 10) begin
      l = $urandom; r = $urandom;
    end else begin
      l = cur_l + 32'($signed($urandom_range(0, 4000)) - 2000);
      r = cur_r + 32'($signed($urandom_range(0, 4000)) - 2000);
    end
    k = $urandom_range(99);
    if (k < 8) e = 24'($urandom);
    else if (k < 12) e = 0;
    else e = 24'($urandom_range(500, 60000));
    k = $urandom_range(99);
    if (k < 3) send(CMD_RESET, 8'($urandom), l, r, e);
    else if (k < 12) begin
      tag = 8'($urandom);
      if (tag == VALID_TAG) tag = ~tag;
      send(CMD_SAMPLE, tag, l, r, e);
    end else send(CMD_SAMPLE, tag, l, r, e);
  endtask

  logic [31:0] dist_set [6] = '{32'h00000000, 32'hFFFFFFFF, 32'h00028F5C, 32'h0000A000,
                                32'h01000000, 32'h00001000};
  logic [31:0] head_set [6] = '{32'h00000000, 32'hFFFFFFFF, 32'h00100000, 32'h0A000000,
                                32'h00004000, 32'h80000001};

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= CMD_SAMPLE;
    in_tdata  <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_DIST_PER_TICK;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(CMD_SAMPLE, VALID_TAG, 32'd100, 32'd50, 24'd1000);
    drain();
    set_reg(CFG_DIST_PER_TICK, 32'h00028F5C);
    set_reg(CFG_HEADING_PER_TICK, 32'h00100000);
    send(CMD_SAMPLE, VALID_TAG, 32'd1000, 32'd1200, 24'd10000);
    send(CMD_SAMPLE, 8'h00, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF);
    send(CMD_SAMPLE, 8'hFF, 32'd0, 32'd0, 24'd0);
    send(CMD_SAMPLE, 8'h94, 32'd5, 32'd5, 24'd5);
    send(CMD_SAMPLE, VALID_TAG, 32'h7FFFFFFF, 32'h80000000, 24'd1);
    send(CMD_SAMPLE, VALID_TAG, 32'h80000000, 32'h7FFFFFFF, 24'd0);
    send(CMD_SAMPLE, VALID_TAG, 32'h80000000, 32'h7FFFFFFF, 24'hFFFFFF);
    send(CMD_RESET, 8'h00, 32'hFFFFFFFF, 32'h12345678, 24'd77);
    send(CMD_RESET, VALID_TAG, 32'd0, 32'd0, 24'd0);
    drain();
    set_reg(CFG_DIST_PER_TICK, 32'hFFFFFFFF);
    set_reg(CFG_HEADING_PER_TICK, 32'hFFFFFFFF);
    send(CMD_SAMPLE, VALID_TAG, 32'h7FFFFFFF, 32'h7FFFFFFF, 24'd1);
    send(CMD_SAMPLE, VALID_TAG, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'd1);
    send(CMD_SAMPLE, VALID_TAG, 32'h80000000, 32'h7FFFFFFF, 24'd1);
    send(CMD_SAMPLE, VALID_TAG, 32'h00000000, 32'hFFFFFFFF, 24'd3);
    send(CMD_SAMPLE, 8'h01, 32'h0, 32'h0, 24'd3);
    send(CMD_RESET, 8'h95, 32'h0, 32'h0, 24'd0);

    for (int p = 0; p < 6; p++) begin
      drain();
      set_reg(CFG_DIST_PER_TICK, dist_set[p]);
      set_reg(CFG_HEADING_PER_TICK, head_set[p]);
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 58; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 58; end
        default: begin gap_pct = 7; stall_pct = 7; end
      endcase
      for (int n = 0; n < 255; n++) begin
        if (p == 2 && n == 40) hold_asks++;
        if (p == 3 && n == 100) drain();
        random_item();
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
